[sv/hsv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hsv_pkg;

  // Saturation is always a 16-bit fraction of full scale.
  localparam int SAT_BITS = 16;

  // Hue sector offsets, in units of dist (a full turn is six sectors).
  localparam int SECTOR_GREEN = 2;
  localparam int SECTOR_BLUE  = 4;
  localparam int SECTORS      = 6;

endpackage
`default_nettype wire

[sv/hsv_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface hsv_in_if #(
  parameter int COMPONENT_BITS = 8
) ();
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red;
  logic [COMPONENT_BITS-1:0] green;
  logic [COMPONENT_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface hsv_out_if #(
  parameter int COMPONENT_BITS = 8,
  parameter int HUE_BITS       = 16
) ();
  logic                      valid;
  logic                      ready;
  logic [HUE_BITS-1:0]       hue;
  logic [15:0]               saturation;
  logic [COMPONENT_BITS-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface
`default_nettype wire

[sv/hsv_prep.sv]
`timescale 1ns / 1ps
`default_nettype none
module hsv_prep import hsv_pkg::*; #(
  parameter int CB    = 8,
  parameter int HB    = 16,
  parameter int STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [CB-1:0]     red,
  input  logic [CB-1:0]     green,
  input  logic [CB-1:0]     blue,
  output logic              out_valid,
  output logic [CB-1:0]     out_bright,
  output logic [CB-1:0]     out_sat_rem,
  output logic [CB-1:0]     out_sat_div,
  output logic [STEPS-1:0]  out_sat_word,
  output logic [CB+2:0]     out_hue_rem,
  output logic [CB+2:0]     out_hue_div,
  output logic [STEPS-1:0]  out_hue_word
);

  localparam int HW = CB + 3;

  logic [CB-1:0]       mx, mn, spread;
  logic [HW-1:0]       dist_w, d6, num;
  logic [CB+STEPS-1:0] sat_dvd;
  logic [HW+STEPS-1:0] hue_dvd;

  logic                valid_r;
  logic [CB-1:0]       bright_r, sat_rem_r, sat_div_r;
  logic [STEPS-1:0]    sat_word_r, hue_word_r;
  logic [HW-1:0]       hue_rem_r, hue_div_r;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    spread = mx - mn;
    dist_w = HW'(spread);
    d6     = (dist_w << 2) + (dist_w << 1);
    // Numerator over 6*spread; ties on the max go red, then green.
    if (red == mx) begin
      if (green >= blue) num = HW'(green) - HW'(blue);
      else               num = d6 - (HW'(blue) - HW'(green));
    end else if (green == mx) begin
      num = HW'(SECTOR_GREEN) * dist_w + HW'(blue) - HW'(red);
    end else begin
      num = HW'(SECTOR_BLUE) * dist_w + HW'(red) - HW'(green);
    end
    // spread * 65535 = (spread << 16) - spread
    sat_dvd = (CB'(0) + (CB+STEPS)'(spread) << SAT_BITS) - (CB+STEPS)'(spread);
    hue_dvd = (HW+STEPS)'(num) << HB;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bright_r   <= mx;
      sat_rem_r  <= sat_dvd[CB+STEPS-1:STEPS];
      sat_word_r <= sat_dvd[STEPS-1:0];
      sat_div_r  <= (mx == '0) ? CB'(1) : mx;
      hue_rem_r  <= hue_dvd[HW+STEPS-1:STEPS];
      hue_word_r <= hue_dvd[STEPS-1:0];
      hue_div_r  <= (spread == '0) ? HW'(1) : d6;
    end
  end

  assign out_valid    = valid_r;
  assign out_bright   = bright_r;
  assign out_sat_rem  = sat_rem_r;
  assign out_sat_div  = sat_div_r;
  assign out_sat_word = sat_word_r;
  assign out_hue_rem  = hue_rem_r;
  assign out_hue_div  = hue_div_r;
  assign out_hue_word = hue_word_r;

endmodule
`default_nettype wire

[sv/hsv_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division step for both the saturation and the hue quotient.
module hsv_cell #(
  parameter int CB    = 8,
  parameter int STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [CB-1:0]     in_bright,
  input  logic [CB-1:0]     in_sat_rem,
  input  logic [CB-1:0]     in_sat_div,
  input  logic [STEPS-1:0]  in_sat_word,
  input  logic [CB+2:0]     in_hue_rem,
  input  logic [CB+2:0]     in_hue_div,
  input  logic [STEPS-1:0]  in_hue_word,
  output logic              out_valid,
  output logic [CB-1:0]     out_bright,
  output logic [CB-1:0]     out_sat_rem,
  output logic [CB-1:0]     out_sat_div,
  output logic [STEPS-1:0]  out_sat_word,
  output logic [CB+2:0]     out_hue_rem,
  output logic [CB+2:0]     out_hue_div,
  output logic [STEPS-1:0]  out_hue_word
);

  localparam int HW = CB + 3;

  logic [CB:0]      sat_t, sat_d;
  logic [HW:0]      hue_t, hue_d;
  logic             sat_q, hue_q;
  logic [CB-1:0]    sat_rem_nxt;
  logic [HW-1:0]    hue_rem_nxt;

  logic             valid_r;
  logic [CB-1:0]    bright_r, sat_rem_r, sat_div_r;
  logic [STEPS-1:0] sat_word_r, hue_word_r;
  logic [HW-1:0]    hue_rem_r, hue_div_r;

  always_comb begin
    // remainder stays below the divisor, so the trial value fits one extra bit
    sat_t = {in_sat_rem, in_sat_word[STEPS-1]};
    sat_d = {1'b0, in_sat_div};
    sat_q = (sat_t >= sat_d);
    sat_rem_nxt = sat_q ? CB'(sat_t - sat_d) : sat_t[CB-1:0];

    hue_t = {in_hue_rem, in_hue_word[STEPS-1]};
    hue_d = {1'b0, in_hue_div};
    hue_q = (hue_t >= hue_d);
    hue_rem_nxt = hue_q ? HW'(hue_t - hue_d) : hue_t[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bright_r   <= in_bright;
      sat_rem_r  <= sat_rem_nxt;
      sat_div_r  <= in_sat_div;
      sat_word_r <= {in_sat_word[STEPS-2:0], sat_q};
      hue_rem_r  <= hue_rem_nxt;
      hue_div_r  <= in_hue_div;
      hue_word_r <= {in_hue_word[STEPS-2:0], hue_q};
    end
  end

  assign out_valid    = valid_r;
  assign out_bright   = bright_r;
  assign out_sat_rem  = sat_rem_r;
  assign out_sat_div  = sat_div_r;
  assign out_sat_word = sat_word_r;
  assign out_hue_rem  = hue_rem_r;
  assign out_hue_div  = hue_div_r;
  assign out_hue_word = hue_word_r;

endmodule
`default_nettype wire

[sv/rgb_to_hsv_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// RGB to HSV pixel converter. Takes one pixel transaction per clock unless
// stalled and returns hue (fraction of a turn scaled by 2^HUE_BITS, floored),
// saturation (floor(dist*65535/max)) and brightness (max component). With
// STEPS = max(16, HUE_BITS), one front stage finds max/min and the
// division operands, then a chain of STEPS identical cells
// each produces one quotient bit of both divisions. The last cell is the
// output register. The whole pipe advances whenever the output is empty or
// being taken, so with out_px.ready held high a pixel enters every cycle.
// Black and grey pixels give zero hue and zero saturation; ties for the
// maximum resolve red first, then green.
module rgb_to_hsv_converter import hsv_pkg::*; #(
  parameter int COMPONENT_BITS = 8,
  parameter int HUE_BITS       = 16
) (
  input logic        clk,
  input logic        rst_n,
  hsv_in_if.sink     in_px,
  hsv_out_if.source  out_px
);

  localparam int CB    = COMPONENT_BITS;
  localparam int HW    = CB + 3;
  localparam int STEPS = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;

  // stage 0 is the front stage output, stage STEPS the output register
  logic             valid    [STEPS+1];
  logic [CB-1:0]    bright   [STEPS+1];
  logic [CB-1:0]    sat_rem  [STEPS+1];
  logic [CB-1:0]    sat_div  [STEPS+1];
  logic [STEPS-1:0] sat_word [STEPS+1];
  logic [HW-1:0]    hue_rem  [STEPS+1];
  logic [HW-1:0]    hue_div  [STEPS+1];
  logic [STEPS-1:0] hue_word [STEPS+1];

  logic advance;

  // global stall: hold everything while a result waits at the output
  assign advance     = out_px.ready || !valid[STEPS];
  assign in_px.ready = advance;

  hsv_prep #(
    .CB    (CB),
    .HB    (HUE_BITS),
    .STEPS (STEPS)
  ) u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (advance),
    .in_valid     (in_px.valid),
    .red          (in_px.red),
    .green        (in_px.green),
    .blue         (in_px.blue),
    .out_valid    (valid[0]),
    .out_bright   (bright[0]),
    .out_sat_rem  (sat_rem[0]),
    .out_sat_div  (sat_div[0]),
    .out_sat_word (sat_word[0]),
    .out_hue_rem  (hue_rem[0]),
    .out_hue_div  (hue_div[0]),
    .out_hue_word (hue_word[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    hsv_cell #(
      .CB    (CB),
      .STEPS (STEPS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (advance),
      .in_valid     (valid[i]),
      .in_bright    (bright[i]),
      .in_sat_rem   (sat_rem[i]),
      .in_sat_div   (sat_div[i]),
      .in_sat_word  (sat_word[i]),
      .in_hue_rem   (hue_rem[i]),
      .in_hue_div   (hue_div[i]),
      .in_hue_word  (hue_word[i]),
      .out_valid    (valid[i+1]),
      .out_bright   (bright[i+1]),
      .out_sat_rem  (sat_rem[i+1]),
      .out_sat_div  (sat_div[i+1]),
      .out_sat_word (sat_word[i+1]),
      .out_hue_rem  (hue_rem[i+1]),
      .out_hue_div  (hue_div[i+1]),
      .out_hue_word (hue_word[i+1])
    );
  end

  // quotient words hold the full results after the last cell; the upper
  // bits are zero since both quotients stay below their full scale
  assign out_px.valid      = valid[STEPS];
  assign out_px.hue        = hue_word[STEPS][HUE_BITS-1:0];
  assign out_px.saturation = sat_word[STEPS][SAT_BITS-1:0];
  assign out_px.brightness = bright[STEPS];

endmodule
`default_nettype wire

[tb/rgb_to_hsv_converter_check.sv]
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsv_converter_check import hsv_pkg::*; #(
  parameter int COMPONENT_BITS = 8,
  parameter int HUE_BITS       = 16
) (
  input  logic clk,
  input  logic rst_n,
  hsv_in_if    px_in,
  hsv_out_if   px_out,
  output int   mismatches,
  output int   pending
);

  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [HUE_BITS-1:0]       hue;
    logic [SAT_BITS-1:0]       saturation;
    logic [COMPONENT_BITS-1:0] brightness;
  } hsv_px_t;

  hsv_px_t hsv_expected[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Exact integer HSV of one pixel; ties for max go red, then green.
  function automatic hsv_px_t hsv_of(logic [COMPONENT_BITS-1:0] r,
                                     logic [COMPONENT_BITS-1:0] g,
                                     logic [COMPONENT_BITS-1:0] b);
    longint unsigned rr, gg, bb, top, bottom, spread, num, sat_full;
    hsv_px_t px;
    rr = r;
    gg = g;
    bb = b;
    top = rr;
    bottom = rr;
    if (gg > top) top = gg;
    if (bb > top) top = bb;
    if (gg < bottom) bottom = gg;
    if (bb < bottom) bottom = bb;
    spread = top - bottom;
    sat_full = (64'd1 << SAT_BITS) - 1;
    px.saturation = (top == 0) ? '0 : SAT_BITS'((spread * sat_full) / top);
    px.hue = '0;
    if (spread != 0) begin
      if (rr == top) begin
        // negative g-b wraps by a full turn
        num = (gg >= bb) ? gg - bb : SECTORS * spread - (bb - gg);
      end else if (gg == top) begin
        num = SECTOR_GREEN * spread + bb - rr;
      end else begin
        num = SECTOR_BLUE * spread + rr - gg;
      end
      px.hue = HUE_BITS'((num << HUE_BITS) / (SECTORS * spread));
    end
    px.brightness = COMPONENT_BITS'(top);
    return px;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < MAX_PRINTED)
      $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    hsv_px_t want;
    int      delta;
    delta = 0;
    if (rst_n) begin
      if (px_in.valid && px_in.ready) begin
        hsv_expected.push_back(hsv_of(px_in.red, px_in.green, px_in.blue));
        delta++;
      end
      if (px_out.valid && px_out.ready) begin
        if (hsv_expected.size() == 0) begin
          report_mismatch("result with no pixel outstanding", px_out.hue, 0);
        end else begin
          want = hsv_expected.pop_front();
          delta--;
          if (px_out.hue !== want.hue)
            report_mismatch("hue", px_out.hue, want.hue);
          if (px_out.saturation !== want.saturation)
            report_mismatch("saturation", px_out.saturation, want.saturation);
          if (px_out.brightness !== want.brightness)
            report_mismatch("brightness", px_out.brightness, want.brightness);
        end
      end
    end
    pending <= pending + delta;
  end

endmodule
`default_nettype wire

[tb/rgb_to_hsv_converter_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsv_converter_test;

  localparam int COMPONENT_BITS = 8;
  localparam int HUE_BITS       = 16;
  localparam int RANDOM_PIXELS  = 2000;
  // Last stretch of the run goes at full rate on both sides.
  localparam int CALM_TAIL      = 300;
  // Pipe depth is max(16, HUE_BITS) + 1; drain wait is a comfortable multiple.
  localparam int DRAIN_CYCLES   = 80;
  // Worst case for ~2000 pixels with the longest source gaps and sink stalls stays far below.
  localparam int CYCLE_LIMIT    = 600000;
  localparam int COMP_MAX       = (1 << COMPONENT_BITS) - 1;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   mismatches;
  int   pending;
  bit   bursts_on = 1'b1;   // shared by source gaps and sink stalls
  bit   done = 1'b0;

  hsv_in_if  #(.COMPONENT_BITS(COMPONENT_BITS)) px_in ();
  hsv_out_if #(.COMPONENT_BITS(COMPONENT_BITS), .HUE_BITS(HUE_BITS)) px_out ();

  rgb_to_hsv_converter #(
    .COMPONENT_BITS(COMPONENT_BITS),
    .HUE_BITS      (HUE_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_px (px_in),
    .out_px(px_out)
  );

  // Watches both channels, predicts every pixel and compares in order.
  rgb_to_hsv_converter_check #(
    .COMPONENT_BITS(COMPONENT_BITS),
    .HUE_BITS      (HUE_BITS)
  ) hsv_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .px_in     (px_in),
    .px_out    (px_out),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the pipe hangs or drops a transaction.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT && !done) begin
      $display("[rgb_to_hsv_converter] ERROR");
      $finish;
    end
  end

  // Result side: ready drops in random bursts while bursts are
  // enabled; otherwise it stays high so the pipe runs at one pixel per clock.
  initial begin
    int stall_left;
    stall_left = 0;
    px_out.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_left > 0)
        stall_left--;
      else if (bursts_on && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 16);
      px_out.ready <= (stall_left == 0);
      @(posedge clk);
    end
  end

  // One pixel transaction: present it, hold until ready is seen at an edge.
  // Called at a rising edge; leaves valid high so back-to-back pixels never
  // see valid lowered and raised within one time step.
  task automatic send_pixel(int r, int g, int b);
    px_in.valid <= 1'b1;
    px_in.red   <= r[COMPONENT_BITS-1:0];
    px_in.green <= g[COMPONENT_BITS-1:0];
    px_in.blue  <= b[COMPONENT_BITS-1:0];
    do @(posedge clk); while (!px_in.ready);
    // optional source gap with valid held low
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      px_in.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Random pixel, half the time shaped toward the interesting corners: ties for max,
  // grey and near-grey, tiny values, and a saturated component.
  task automatic pick_pixel(output int r, output int g, output int b);
    int base;
    r = $urandom_range(0, COMP_MAX);
    g = $urandom_range(0, COMP_MAX);
    b = $urandom_range(0, COMP_MAX);
    case ($urandom_range(0, 9))
      0: begin                       // two-way tie for the maximum
        base = $urandom_range(0, COMP_MAX);
        r = base;
        g = base;
        b = $urandom_range(0, base);
        case ($urandom_range(0, 2))
          0: ;
          1: begin r = b; b = base; end
          2: begin g = b; b = base; end
          default: ;
        endcase
      end
      1: begin                       // grey, including black and white
        g = r;
        b = r;
      end
      2: begin                       // near-grey
        base = $urandom_range(1, COMP_MAX - 1);
        r = base + $urandom_range(0, 2) - 1;
        g = base + $urandom_range(0, 2) - 1;
        b = base + $urandom_range(0, 2) - 1;
      end
      3: begin                       // tiny components
        r = $urandom_range(0, 3);
        g = $urandom_range(0, 3);
        b = $urandom_range(0, 3);
      end
      4: begin                       // one full-scale component
        case ($urandom_range(0, 2))
          0: r = COMP_MAX;
          1: g = COMP_MAX;
          2: b = COMP_MAX;
          default: ;
        endcase
      end
      default: ;                     // uniform
    endcase
  endtask

  initial begin
    int r, g, b;
    rst_n       = 1'b0;
    px_in.valid = 1'b0;
    px_in.red   = '0;
    px_in.green = '0;
    px_in.blue  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: black, greys, primaries, tie order, hue wrap near red.
    send_pixel(0, 0, 0);
    send_pixel(COMP_MAX, COMP_MAX, COMP_MAX);
    send_pixel(128, 128, 128);
    send_pixel(COMP_MAX, 0, 0);
    send_pixel(0, COMP_MAX, 0);
    send_pixel(0, 0, COMP_MAX);
    send_pixel(COMP_MAX, COMP_MAX, 0);     // red/green tie -> red sector
    send_pixel(0, COMP_MAX, COMP_MAX);     // green/blue tie -> green sector
    send_pixel(COMP_MAX, 0, COMP_MAX);     // red/blue tie -> red sector, wraps
    send_pixel(COMP_MAX, 0, 1);            // red max, g < b: just below a full turn
    send_pixel(COMP_MAX, 1, 0);
    send_pixel(1, 0, 0);
    send_pixel(0, 1, 0);
    send_pixel(0, 0, 1);
    send_pixel(1, 1, 0);
    send_pixel(0, 1, 1);
    send_pixel(200, 10, 20);
    send_pixel(20, 200, 10);
    send_pixel(10, 20, 200);
    send_pixel(COMP_MAX, COMP_MAX - 1, 0);
    send_pixel(170, 85, 0);
    send_pixel(85, 170, COMP_MAX);

    // Random part: idling alternates on and off in blocks, then a calm tail.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      bursts_on = (i < RANDOM_PIXELS - CALM_TAIL) && ((i / 250) % 3 != 2);
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end
    px_in.valid <= 1'b0;

    // Let the last transaction land in the checker, then drain the pipe.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    done = 1'b1;
    if (mismatches == 0 && pending == 0) begin
      $display("[rgb_to_hsv_converter] OK");
    end else begin
      $display("[rgb_to_hsv_converter] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
sv/hsv_pkg.sv
sv/hsv_if.sv
sv/hsv_prep.sv
sv/hsv_cell.sv
sv/rgb_to_hsv_converter.sv
tb/rgb_to_hsv_converter_check.sv
tb/rgb_to_hsv_converter_test.sv
